[src/sse_pkg.sv]
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants for the sparse set engine: operation and
// status codes, fixed field widths of the item and result.
// ----------------------------------------------------------------------------
`default_nettype none

package sse_pkg;

    // fixed field widths
    localparam int VALUE_W  = 10;
    localparam int POP_W    = 11;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_POP    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_CHANGED   = 2'd0,
        ST_SAME      = 2'd1,
        ST_EMPTY_POP = 2'd2
    } status_t;

endpackage

`default_nettype wire

[src/sparse_set_engine.sv]
// ----------------------------------------------------------------------------
// sparse_set_engine
// Sparse set over 0 .. UNIVERSE-1 with insert, delete, pop and clear; a
// dense member list and a sparse index map in synchronous RAMs.
//
//   channel  | direction | handshake            | fields
//   ---------+-----------+----------------------+-----------------------------
//   item     | in        | in_valid / in_stall  | op, value
//   result   | out       | out_valid / out_stall| popped_value, status,
//            |           |                      | population, is_empty
//
// insert passes S_LOOKUP and S_CHECK, delete also S_LAST when present, pop
// S_POP, clear and the cases decided at once (out of range, pop on empty)
// S_SIMPLE; the dependent sparse-map then dense-list RAM reads set these steps.
// Reset clears the state, population and result register but not the RAMs;
// RAM contents need no clearing because the membership check rejects any stale entry.
// A stalled result holds the engine in its final step; in_stall is high from
// the transfer until the result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_set_engine
    import sse_pkg::*;
#(
    parameter int UNIVERSE = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [VALUE_W-1:0]  value,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [VALUE_W-1:0]  popped_value,
    output logic      [STATUS_W-1:0] status,
    output logic      [POP_W-1:0]    population,
    output logic                     is_empty
);

    localparam int IDX_W = (UNIVERSE > 1) ? $clog2(UNIVERSE) : 1;
    localparam int CNT_W = $clog2(UNIVERSE + 1);

    logic               dense_we;
    logic [IDX_W-1:0]   dense_waddr;
    logic [VALUE_W-1:0] dense_wdata;
    logic               dense_re;
    logic [IDX_W-1:0]   dense_raddr;
    logic [VALUE_W-1:0] dense_rdata;
    logic               sparse_we;
    logic [IDX_W-1:0]   sparse_waddr;
    logic [IDX_W-1:0]   sparse_wdata;
    logic               sparse_re;
    logic [IDX_W-1:0]   sparse_raddr;
    logic [IDX_W-1:0]   sparse_rdata;

    // dense member list, indexed by slot
    sse_ram #(
        .DEPTH  (UNIVERSE),
        .ADDR_W (IDX_W),
        .DATA_W (VALUE_W)
    ) u_dense (
        .clk   (clk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .re    (dense_re),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    // sparse index map, indexed by value
    sse_ram #(
        .DEPTH  (UNIVERSE),
        .ADDR_W (IDX_W),
        .DATA_W (IDX_W)
    ) u_sparse (
        .clk   (clk),
        .we    (sparse_we),
        .waddr (sparse_waddr),
        .wdata (sparse_wdata),
        .re    (sparse_re),
        .raddr (sparse_raddr),
        .rdata (sparse_rdata)
    );

    // operation sequencer
    sse_ctrl #(
        .UNIVERSE (UNIVERSE),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .status       (status),
        .population   (population),
        .is_empty     (is_empty),
        .dense_we     (dense_we),
        .dense_waddr  (dense_waddr),
        .dense_wdata  (dense_wdata),
        .dense_re     (dense_re),
        .dense_raddr  (dense_raddr),
        .dense_rdata  (dense_rdata),
        .sparse_we    (sparse_we),
        .sparse_waddr (sparse_waddr),
        .sparse_wdata (sparse_wdata),
        .sparse_re    (sparse_re),
        .sparse_raddr (sparse_raddr),
        .sparse_rdata (sparse_rdata)
    );

    // engine is busy right after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item transfer not followed by busy");

    // population only moves together with a freshly loaded result
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(population) |-> out_valid)
        else $error("population changed without a result");

    // pop on empty reports an empty set and no element
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY_POP)) |-> (is_empty && (popped_value == '0)))
        else $error("empty pop result inconsistent");

endmodule

`default_nettype wire

[src/sse_ram.sv]
// ----------------------------------------------------------------------------
// sse_ram
// Simple dual-port synchronous RAM, one write and one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/sse_ctrl.sv]
// ----------------------------------------------------------------------------
// sse_ctrl
// Operation sequencer of the sparse set engine: takes one item, walks the
// sparse map and dense list through their RAM ports, checks membership,
// writes back and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_ctrl
    import sse_pkg::*;
#(
    parameter int UNIVERSE = 1024,
    parameter int IDX_W    = 10,
    parameter int CNT_W    = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // item channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [VALUE_W-1:0]  value,
    // result channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [VALUE_W-1:0]  popped_value,
    output logic      [STATUS_W-1:0] status,
    output logic      [POP_W-1:0]    population,
    output logic                     is_empty,
    // dense list port
    output logic                     dense_we,
    output logic      [IDX_W-1:0]    dense_waddr,
    output logic      [VALUE_W-1:0]  dense_wdata,
    output logic                     dense_re,
    output logic      [IDX_W-1:0]    dense_raddr,
    input  wire logic [VALUE_W-1:0]  dense_rdata,
    // sparse map port
    output logic                     sparse_we,
    output logic      [IDX_W-1:0]    sparse_waddr,
    output logic      [IDX_W-1:0]    sparse_wdata,
    output logic                     sparse_re,
    output logic      [IDX_W-1:0]    sparse_raddr,
    input  wire logic [IDX_W-1:0]    sparse_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIMPLE,
        S_LOOKUP,
        S_CHECK,
        S_LAST,
        S_POP
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   popped_reg, popped_next;
    status_t              status_reg, status_next;

    op_t                  op_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [IDX_W-1:0]     slot_reg;
    status_t              pend_reg, pend_next;

    op_t                  in_op;
    logic                 in_take;
    logic                 out_free;
    logic                 emit;
    logic                 in_range;
    logic                 member;
    logic                 last_in_range;
    logic [CNT_W-1:0]     count_dec;

    assign in_op         = op_t'(op);
    assign in_stall      = (state_reg != S_IDLE);
    assign in_take       = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign in_range      = (32'(value) < UNIVERSE);
    assign last_in_range = (32'(dense_rdata) < UNIVERSE);
    assign count_dec     = count_reg - 1'b1;

    // membership: slot below population and dense entry points back
    assign member = (CNT_W'(slot_reg) < count_reg) && (dense_rdata == value_reg);

    // sequencing, RAM access and result formation
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pend_next    = pend_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        emit         = 1'b0;
        dense_we     = 1'b0;
        dense_waddr  = slot_reg;
        dense_wdata  = dense_rdata;
        dense_re     = 1'b0;
        dense_raddr  = IDX_W'(count_dec);
        sparse_we    = 1'b0;
        sparse_waddr = IDX_W'(dense_rdata);
        sparse_wdata = slot_reg;
        sparse_re    = 1'b0;
        sparse_raddr = IDX_W'(value);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    unique case (in_op)
                        OP_INSERT, OP_DELETE:
                        begin
                            if (in_range)
                            begin
                                sparse_re  = 1'b1;
                                state_next = S_LOOKUP;
                            end
                            else
                            begin
                                pend_next  = ST_SAME;
                                state_next = S_SIMPLE;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next  = ST_EMPTY_POP;
                                state_next = S_SIMPLE;
                            end
                            else
                            begin
                                dense_re   = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            pend_next  = (count_reg != '0) ? ST_CHANGED : ST_SAME;
                            state_next = S_SIMPLE;
                        end
                    endcase
                end
            end

            // result already known, wait for the output register
            S_SIMPLE:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    status_next = pend_reg;
                    popped_next = '0;
                    if (op_reg == OP_CLEAR)
                    begin
                        count_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            // sparse entry in hand, fetch the dense slot it names
            S_LOOKUP:
            begin
                dense_re    = 1'b1;
                dense_raddr = sparse_rdata;
                state_next  = S_CHECK;
            end

            S_CHECK:
            begin
                if (op_reg == OP_DELETE)
                begin
                    if (member)
                    begin
                        // fetch the last member to fill the hole
                        dense_re   = 1'b1;
                        state_next = S_LAST;
                    end
                    else if (out_free)
                    begin
                        emit        = 1'b1;
                        status_next = ST_SAME;
                        popped_next = '0;
                        state_next  = S_IDLE;
                    end
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    popped_next = '0;
                    state_next  = S_IDLE;
                    if (member || (32'(count_reg) >= UNIVERSE))
                    begin
                        status_next = ST_SAME;
                    end
                    else
                    begin
                        // append at the end of the dense list
                        dense_we     = 1'b1;
                        dense_waddr  = IDX_W'(count_reg);
                        dense_wdata  = value_reg;
                        sparse_we    = 1'b1;
                        sparse_waddr = IDX_W'(value_reg);
                        sparse_wdata = IDX_W'(count_reg);
                        count_next   = count_reg + 1'b1;
                        status_next  = ST_CHANGED;
                    end
                end
            end

            // move the last member into the freed slot
            S_LAST:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    dense_we     = 1'b1;
                    dense_waddr  = slot_reg;
                    dense_wdata  = dense_rdata;
                    sparse_we    = last_in_range;
                    sparse_waddr = IDX_W'(dense_rdata);
                    sparse_wdata = slot_reg;
                    count_next   = count_dec;
                    status_next  = ST_CHANGED;
                    popped_next  = '0;
                    state_next   = S_IDLE;
                end
            end

            S_POP:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    popped_next = dense_rdata;
                    count_next  = count_dec;
                    status_next = ST_CHANGED;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid: loaded on emit, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state, population and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            popped_reg    <= '0;
            status_reg    <= ST_SAME;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            popped_reg    <= popped_next;
            status_reg    <= status_next;
        end
    end

    // captured item and working slot
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= in_op;
            value_reg <= value;
        end
        if (state_reg == S_LOOKUP)
        begin
            slot_reg <= sparse_rdata;
        end
        pend_reg <= pend_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign population   = POP_W'(count_reg);
    assign is_empty     = (count_reg == '0);

endmodule

`default_nettype wire
